// ===== hw/rtl/aes128_block_cipher_macros.svh =====
// Assertion macros for the AES-128 block cipher checker
`ifndef AES128_BLOCK_CIPHER_MACROS_SVH
`define AES128_BLOCK_CIPHER_MACROS_SVH
// assert that a implies b on the same edge
`define AES_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("%m: label failed");
// assert that a implies b on the next edge
`define AES_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("%m: label failed");
`endif

// ===== hw/rtl/aes_pkg.sv =====
// Package for the AES-128 block cipher: types, constants and byte functions
package aes_pkg;
  localparam int NumRounds = 10;
  localparam int NumStages = NumRounds + 1;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxW-1:0] RegKeyLow = 1'b1;
  localparam logic KindEncrypt = 1'b0;
  localparam logic KindDecrypt = 1'b1;

  typedef logic [127:0] block_t;

  typedef struct packed {
    logic   kind;
    block_t data;
  } item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // next round key from the previous one; rc is that round's constant
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

  // byte n of the state sits at bits 127-8n; row n%4, column n/4
  function automatic block_t shift_rows(input block_t s, input logic inv);
    block_t t;
    int src;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = inv ? r + 4 * ((c + 3 * r) % 4) : r + 4 * ((c + r) % 4);
        t[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * src -: 8];
      end
    end
    shift_rows = t;
  endfunction

  function automatic block_t sub_bytes(input block_t s, input logic inv);
    block_t t;
    for (int n = 0; n < 16; n++) begin
      t[8 * n +: 8] = inv ? INV_SBOX[s[8 * n +: 8]] : SBOX[s[8 * n +: 8]];
    end
    sub_bytes = t;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m0 [4];
    logic [31:0] res;
    for (int k = 0; k < 4; k++) begin
      a[k]  = col[31 - 8 * k -: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      if (inv) begin
        m0[k] = x8[k] ^ x4[k] ^ x2[k];
        m1[k] = x8[k] ^ x2[k] ^ a[k];
        m2[k] = x8[k] ^ x4[k] ^ a[k];
        m3[k] = x8[k] ^ a[k];
      end else begin
        m0[k] = x2[k];
        m1[k] = x2[k] ^ a[k];
        m2[k] = a[k];
        m3[k] = a[k];
      end
    end
    // coefficient for input k at output r is coef[(k - r) mod 4]
    for (int r = 0; r < 4; r++) begin
      res[31 - 8 * r -: 8] = m0[r] ^ m1[(r + 1) % 4] ^ m2[(r + 2) % 4] ^ m3[(r + 3) % 4];
    end
    mix_col = res;
  endfunction

  function automatic block_t mix_columns(input block_t s, input logic inv);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      t[127 - 32 * c -: 32] = mix_col(s[127 - 32 * c -: 32], inv);
    end
    mix_columns = t;
  endfunction
endpackage

// ===== hw/rtl/aes_stream_if.sv =====
// Valid/ready channel interfaces for requests, results and key writes
interface aes_req_if;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [63:0]      block_high;
  logic [63:0]      block_low;
  modport source (output valid, kind, block_high, block_low, input ready);
  modport sink (input valid, kind, block_high, block_low, output ready);
endinterface

interface aes_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/aes128_block_cipher.sv =====
// Top level of the pipelined AES-128 block cipher
// Usage:
//   req: valid/ready channel with kind (0 encrypt, 1 decrypt) and the block
//   as block_high/block_low, first byte most significant.
//   res: valid/ready channel with result_high/result_low, one per request.
//   cfg: key write channel, index 0 key_high, index 1 key_low; always ready.
//   Write the key only while no request is in flight.
// Timing:
//   An initial key-add stage, then ten round stages. One request per cycle
//   sustained while res.ready keeps the pipeline moving and the round keys
//   are ready; the rate is set by one cipher round per pipeline stage.
//   Round keys are expanded in a registered chain, so req.ready stays low
//   after reset and after each key write until the chain has settled.
// Reset: clears the key to zero and all stage valid bits.
// Stall: when the last stage holds a result and res.ready is low, the whole
//   pipeline holds and req.ready is low, so nothing is lost or repeated.
module aes128_block_cipher
  import aes_pkg::*;
(
  input logic clk,
  input logic rst,
  aes_req_if.sink   req,
  aes_res_if.source res,
  aes_cfg_if.sink   cfg
);
  logic [63:0] key_high, key_low;
  block_t      round_key [NumStages];
  logic        v [NumStages];
  item_t       it [NumStages];
  logic        en;
  logic        keys_ready;
  item_t       in_item;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == RegKeyHigh) key_high <= cfg.data;
      if (cfg.index == RegKeyLow) key_low <= cfg.data;
    end
  end

  aes_key_sched u_keys (
    .clk(clk), .rst(rst), .load(cfg.valid && cfg.ready),
    .key({key_high, key_low}), .round_key(round_key), .keys_ready(keys_ready)
  );

  // global stall only when the output stage holds an untaken result
  assign en = !v[NumStages - 1] || res.ready;
  assign req.ready = en && keys_ready;
  assign in_item.kind = req.kind;
  assign in_item.data = {req.block_high, req.block_low} ^
                        ((req.kind == KindDecrypt) ? round_key[NumRounds] : round_key[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= req.valid && keys_ready;
    end
  end
  always_ff @(posedge clk) begin
    if (en) it[0] <= in_item;
  end

  for (genvar g = 1; g < NumStages; g++) begin : g_round
    aes_round u_round (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(v[g - 1]), .in_item(it[g - 1]),
      .key_enc(round_key[g]), .key_dec(round_key[NumRounds - g]),
      .last(g == NumRounds),
      .out_valid(v[g]), .out_item(it[g])
    );
  end

  assign res.valid       = v[NumStages - 1];
  assign res.result_high = it[NumStages - 1].data[127:64];
  assign res.result_low  = it[NumStages - 1].data[63:0];
endmodule

// ===== hw/rtl/aes_key_sched.sv =====
// Round key expansion from the key registers, one registered round per stage
module aes_key_sched
  import aes_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  block_t key,
  output block_t round_key [NumStages],
  output logic   keys_ready
);
  logic [3:0] settle;

  assign round_key[0] = key;

  for (genvar g = 1; g < NumStages; g++) begin : g_key
    always_ff @(posedge clk) begin
      round_key[g] <= next_key(round_key[g - 1], RCON[g - 1]);
    end
  end

  // the chain needs to settle through every round key register after a key change
  always_ff @(posedge clk) begin
    if (rst || load) begin
      settle <= 4'(NumRounds);
    end else if (settle != 4'd0) begin
      settle <= settle - 4'd1;
    end
  end

  assign keys_ready = (settle == 4'd0);
endmodule

// ===== hw/rtl/aes_round.sv =====
// One registered cipher round, encrypt or decrypt path chosen per item
module aes_round
  import aes_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  item_t  in_item,
  input  block_t key_enc,
  input  block_t key_dec,
  input  logic   last,
  output logic   out_valid,
  output item_t  out_item
);
  block_t e, d;
  always_comb begin
    e = shift_rows(sub_bytes(in_item.data, 1'b0), 1'b0);
    if (!last) e = mix_columns(e, 1'b0);
    e = e ^ key_enc;
    d = sub_bytes(shift_rows(in_item.data, 1'b1), 1'b1) ^ key_dec;
    if (!last) d = mix_columns(d, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.kind <= in_item.kind;
      out_item.data <= (in_item.kind == KindDecrypt) ? d : e;
    end
  end
endmodule

// ===== hw/rtl/aes_checker.sv =====
// Port-level assertions for the AES-128 block cipher, bound to the top level
`include "aes128_block_cipher_macros.svh"
module aes_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [63:0] result_high,
  input logic        cfg_ready
);
  // result held under stall
  `AES_ASSERT_NEXT(res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(result_high))
  // request side blocked while a result waits untaken
  `AES_ASSERT_IMP(ready_stall, clk, rst, res_valid && !res_ready, !req_ready)
  // key port never back-pressures
  `AES_ASSERT_IMP(cfg_always, clk, rst, 1'b1, cfg_ready)
  // after reset nothing comes out the next cycle
  `AES_ASSERT_IMP(no_early, clk, rst, $past(rst), !res_valid)
endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready),
  .result_high(res.result_high), .cfg_ready(cfg.ready)
);
